/* hdl/bitmap_row_pixel_unpacker_assert.svh */
// assertion helpers for the unpacker modules, used by the back end
// each expects clk and rst in the scope where it is used
`ifndef BITMAP_ROW_PIXEL_UNPACKER_ASSERT_SVH
`define BITMAP_ROW_PIXEL_UNPACKER_ASSERT_SVH
`ifndef SYNTH
// consequent checked in the same cycle
`define BRU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// consequent checked in the next cycle
`define BRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BRU_ASSERT_SAME(lbl, ante, cons, msg)
`define BRU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/bru_pkg.sv */
package bru_pkg;

  // pixel format register codes
  localparam logic [2:0] FMT_1BPP  = 3'd0;
  localparam logic [2:0] FMT_4BPP  = 3'd1;
  localparam logic [2:0] FMT_8BPP  = 3'd2;
  localparam logic [2:0] FMT_24BPP = 3'd3;
  localparam logic [2:0] FMT_32BPP = 3'd4;

  // register indexes on the config port
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // queue entry kinds
  localparam logic [2:0] KIND_WRITE = 3'd0;
  localparam logic [2:0] KIND_PAL1  = 3'd1;
  localparam logic [2:0] KIND_PAL4  = 3'd2;
  localparam logic [2:0] KIND_PAL8  = 3'd3;
  localparam logic [2:0] KIND_DIR24 = 3'd4;
  localparam logic [2:0] KIND_DIR32 = 3'd5;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // config as seen by the front
  typedef struct packed {
    logic [2:0]  fmt;
    logic [12:0] width;        // clamped width
    logic [11:0] last_row;     // clamped height minus one
    logic        restart;      // a register write restarts the frame
    logic [11:0] restart_row;  // first row after that write
  } cfg_t;

  // one piece of work for the back
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;   // data byte, or palette index for a write
    logic [23:0] rgb;    // direct colour, or palette colour for a write
    logic [11:0] x;      // column of first pixel
    logic [11:0] y;
    logic [3:0]  count;  // pixels to emit, 1..8
  } entry_t;

endpackage

/* hdl/bru_ifs.sv */
// input request channel
interface bru_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] palette_index;
  logic [7:0] palette_red;
  logic [7:0] palette_green;
  logic [7:0] palette_blue;
  logic [7:0] data_byte;

  modport source (
    output valid, cmd, palette_index, palette_red, palette_green, palette_blue,
           data_byte,
    input  ready
  );
  modport sink (
    input  valid, cmd, palette_index, palette_red, palette_green, palette_blue,
           data_byte,
    output ready
  );
endinterface

// output pixel channel
interface bru_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_in_run;

  modport source (
    output valid, pixel_x, pixel_y, red, green, blue, last_in_run,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, red, green, blue, last_in_run,
    output ready
  );
endinterface

/* hdl/bru_front.sv */
module bru_front (
  input  logic            clk,
  input  logic            rst,
  input  bru_pkg::cfg_t   cfg,
  bru_in_if.sink          pix_in,
  input  logic            q_full,
  output logic            q_push,
  output bru_pkg::entry_t q_wdata
);
  import bru_pkg::*;

  logic [14:0] p;        // byte position in row
  logic [13:0] col;      // direct colour column
  logic [1:0]  ch;       // direct colour byte within pixel
  logic [23:0] partial;  // gathered direct colour bytes
  logic [11:0] row;

  logic        accept;
  logic        is_data;
  logic [2:0]  mode;
  logic [14:0] row_len;
  logic [15:0] p_inc;
  logic        row_end;
  logic [17:0] w18;
  logic [17:0] x0;
  logic [17:0] diff;
  logic        in_row;
  logic [3:0]  cap;
  logic [3:0]  cnt;
  logic        is_direct;
  logic        ch_done;
  logic [23:0] direct_rgb;

  assign pix_in.ready = !q_full;
  assign accept       = pix_in.valid && pix_in.ready;
  assign is_data      = pix_in.cmd;

  // format decode, unknown codes act as 8bpp
  always_comb begin
    unique case (cfg.fmt)
      FMT_1BPP:  mode = KIND_PAL1;
      FMT_4BPP:  mode = KIND_PAL4;
      FMT_24BPP: mode = KIND_DIR24;
      FMT_32BPP: mode = KIND_DIR32;
      default:   mode = KIND_PAL8;
    endcase
  end

  // padded row length in bytes
  assign w18 = 18'(cfg.width);
  always_comb begin
    unique case (mode)
      KIND_PAL1:  row_len = 15'(((w18 + 18'd31) >> 5) << 2);
      KIND_PAL4:  row_len = 15'(((w18 + 18'd7) >> 3) << 2);
      KIND_DIR24: row_len = 15'(((18'({cfg.width, 4'b0000}) +
                                  18'({cfg.width, 3'b000}) + 18'd31) >> 5) << 2);
      KIND_DIR32: row_len = 15'({cfg.width, 2'b00});
      default:    row_len = 15'((w18 + 18'd3) >> 2 << 2);
    endcase
  end

  assign p_inc   = 16'(p) + 16'd1;
  assign row_end = p_inc >= 16'(row_len);

  // first column and pixel count of this byte
  assign is_direct = (mode == KIND_DIR24) || (mode == KIND_DIR32);
  assign ch_done   = (mode == KIND_DIR24) ? (ch == 2'd2) : (ch == 2'd3);

  always_comb begin
    unique case (mode)
      KIND_PAL1: begin
        x0  = 18'({p, 3'b000});
        cap = 4'd8;
      end
      KIND_PAL4: begin
        x0  = 18'({p, 1'b0});
        cap = 4'd2;
      end
      KIND_DIR24, KIND_DIR32: begin
        x0  = 18'(col);
        cap = 4'd1;
      end
      default: begin
        x0  = 18'(p);
        cap = 4'd1;
      end
    endcase
  end

  assign in_row = x0 < w18;
  assign diff   = w18 - x0;

  always_comb begin
    if (!in_row || (is_direct && !ch_done)) begin
      cnt = 4'd0;
    end else if (diff >= 18'(cap)) begin
      cnt = cap;
    end else begin
      cnt = diff[3:0];
    end
  end

  assign direct_rgb = (mode == KIND_DIR24) ? {pix_in.data_byte, partial[15:0]} : partial;

  // classify the request into a queue entry
  always_comb begin
    q_wdata.x     = x0[11:0];
    q_wdata.y     = row;
    q_wdata.count = cnt;
    if (!is_data) begin
      q_wdata.kind = KIND_WRITE;
      q_wdata.data = pix_in.palette_index;
      q_wdata.rgb  = {pix_in.palette_red, pix_in.palette_green, pix_in.palette_blue};
    end else begin
      q_wdata.kind = mode;
      q_wdata.data = pix_in.data_byte;
      q_wdata.rgb  = direct_rgb;
    end
  end

  assign q_push = accept && (!is_data || (cnt != 4'd0));

  // row walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      p       <= '0;
      col     <= '0;
      ch      <= '0;
      partial <= '0;
      row     <= '0;
    end else if (cfg.restart) begin
      p       <= '0;
      col     <= '0;
      ch      <= '0;
      partial <= '0;
      row     <= cfg.restart_row;
    end else if (accept && is_data) begin
      if (row_end) begin
        p       <= '0;
        col     <= '0;
        ch      <= '0;
        partial <= '0;
        if (row == 12'd0 || row > cfg.last_row) begin
          row <= cfg.last_row;
        end else begin
          row <= row - 12'd1;
        end
      end else begin
        p <= p_inc[14:0];
        if (is_direct) begin
          if (ch_done) begin
            ch  <= 2'd0;
            col <= col + 14'd1;
          end else begin
            ch <= ch + 2'd1;
          end
          unique case (ch)
            2'd0:    partial <= {16'd0, pix_in.data_byte};
            2'd1:    partial <= {8'd0, pix_in.data_byte, partial[7:0]};
            2'd2:    partial <= {pix_in.data_byte, partial[15:0]};
            default: partial <= partial;
          endcase
        end
      end
    end
  end

endmodule

/* hdl/bru_queue.sv */
module bru_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bru_pkg::entry_t wdata,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output bru_pkg::entry_t head
);
  import bru_pkg::*;

  entry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign full       = fill == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

/* hdl/bru_back.sv */
module bru_back #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  bru_pkg::entry_t head,
  output logic            pop,
  bru_out_if.source       pix_out
);
  import bru_pkg::*;
  `include "bitmap_row_pixel_unpacker_assert.svh"

  localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [23:0]  palette [PALETTE_DEPTH];
  logic [2:0]   k;          // pixel within current entry

  logic         is_write;
  logic         is_pal;
  logic [7:0]   idx;
  logic         idx_ok;
  logic         pix_last;
  logic         issue;
  logic         wr_en;
  logic         rd_en;

  // lookup stage
  logic         rd_valid;
  logic [23:0]  rd_data;
  logic         rd_use_mem;
  logic [23:0]  rd_rgb;
  logic [11:0]  rd_x;
  logic [11:0]  rd_y;
  logic         rd_last;
  logic         rd_free;
  logic         out_load;

  // output register
  logic         out_valid;
  logic [11:0]  out_x;
  logic [11:0]  out_y;
  logic [23:0]  out_rgb;
  logic         out_last;

  assign is_write = head.kind == KIND_WRITE;
  assign is_pal   = (head.kind == KIND_PAL1) || (head.kind == KIND_PAL4) ||
                    (head.kind == KIND_PAL8);

  // palette index of the current pixel
  always_comb begin
    unique case (head.kind)
      KIND_PAL1: idx = {7'd0, head.data[3'd7 - k]};
      KIND_PAL4: idx = (k == 3'd0) ? {4'd0, head.data[7:4]} : {4'd0, head.data[3:0]};
      default:   idx = head.data;
    endcase
  end

  assign idx_ok   = 9'(idx) < 9'(PALETTE_DEPTH);
  assign pix_last = (4'(k) + 4'd1) == head.count;

  assign out_load = rd_valid && (!out_valid || pix_out.ready);
  assign rd_free  = !rd_valid || out_load;
  assign issue    = head_valid && !is_write && rd_free;
  assign wr_en    = head_valid && is_write && idx_ok;
  assign rd_en    = issue && is_pal && idx_ok;
  assign pop      = head_valid && (is_write || (issue && pix_last));

  // palette memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette[idx[PAW-1:0]] <= head.rgb;
    end
    if (rd_en) begin
      rd_data <= palette[idx[PAW-1:0]];
    end
  end

  // pixel counter within the entry
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (issue) begin
      k <= pix_last ? 3'd0 : k + 3'd1;
    end
  end

  // lookup stage control and tags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (issue) begin
      rd_valid <= 1'b1;
    end else if (out_load) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_use_mem <= is_pal && idx_ok;
      rd_rgb     <= is_pal ? 24'd0 : head.rgb;
      rd_x       <= head.x + 12'(k);
      rd_y       <= head.y;
      rd_last    <= pix_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x    <= rd_x;
      out_y    <= rd_y;
      out_rgb  <= rd_use_mem ? rd_data : rd_rgb;
      out_last <= rd_last;
    end
  end

  assign pix_out.valid       = out_valid;
  assign pix_out.pixel_x     = out_x;
  assign pix_out.pixel_y     = out_y;
  assign pix_out.red         = out_rgb[23:16];
  assign pix_out.green       = out_rgb[15:8];
  assign pix_out.blue        = out_rgb[7:0];
  assign pix_out.last_in_run = out_last;

  // checks
  `BRU_ASSERT_SAME(a_rd_slot_free, rd_en, !rd_valid || out_load, "lookup overwrote a held pixel")
  `BRU_ASSERT_SAME(a_k_in_range, head_valid && !is_write, 4'(k) < head.count, "pixel counter past entry")
  `BRU_ASSERT_SAME(a_last_pops, issue && pix_last, pop, "finished entry not released")
  `BRU_ASSERT_NEXT(a_out_loaded, out_load, out_valid, "loaded pixel not presented")

endmodule

/* hdl/bitmap_row_pixel_unpacker.sv */
// path: queue, lookup stage, output register, then the pixel is presented
// throughput: one pixel per cycle while the output is ready; a byte that yields
//   several pixels holds the queue head, set by the single palette read port
// palette writes need no lookup; bytes that yield no pixel are not queued
// reset: format 8bpp, width 1, height 1, row state and queue cleared;
//   palette contents are undefined until written
module bitmap_row_pixel_unpacker #(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  bru_in_if.sink      pix_in,
  bru_out_if.source   pix_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bru_pkg::*;

  logic [2:0]  fmt;
  logic [12:0] width;
  logic [12:0] height;
  logic [1:0]  reg_idx;
  logic        wr;
  logic        wr_valid_reg;
  logic [12:0] next_height;
  logic [12:0] eff_width;
  cfg_t        cfg;

  logic        q_push;
  entry_t      q_wdata;
  logic        q_pop;
  logic        q_full;
  logic        q_head_valid;
  entry_t      q_head;

  function automatic logic [12:0] clamp_height(input logic [12:0] h);
    logic [12:0] r;
    if (h == 13'd0) begin
      r = 13'd1;
    end else if (h > 13'd4096) begin
      r = 13'd4096;
    end else begin
      r = h;
    end
    return r;
  endfunction

  // config register writes
  assign pready       = 1'b1;
  assign reg_idx      = paddr[3:2];
  assign wr           = psel && penable && pwrite;
  assign wr_valid_reg = (reg_idx == REG_FORMAT) || (reg_idx == REG_WIDTH) ||
                        (reg_idx == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt    <= FMT_8BPP;
      width  <= 13'd1;
      height <= 13'd1;
    end else if (wr) begin
      unique case (reg_idx)
        REG_FORMAT: fmt    <= pwdata[2:0];
        REG_WIDTH:  width  <= pwdata[12:0];
        REG_HEIGHT: height <= pwdata[12:0];
        default:    ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_FORMAT: prdata = 32'(fmt);
      REG_WIDTH:  prdata = 32'(width);
      REG_HEIGHT: prdata = 32'(height);
      default:    prdata = 32'd0;
    endcase
  end

  // clamped geometry for the front
  always_comb begin
    if (width == 13'd0) begin
      eff_width = 13'd1;
    end else if (15'(width) > 15'(MAX_WIDTH)) begin
      eff_width = 13'(MAX_WIDTH);
    end else begin
      eff_width = width;
    end
  end

  assign next_height = (wr && reg_idx == REG_HEIGHT) ? pwdata[12:0] : height;

  always_comb begin
    cfg.fmt         = fmt;
    cfg.width       = eff_width;
    cfg.last_row    = 12'(clamp_height(height) - 13'd1);
    cfg.restart     = wr && wr_valid_reg;
    cfg.restart_row = 12'(clamp_height(next_height) - 13'd1);
  end

  bru_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pix_in  (pix_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  bru_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .wdata      (q_wdata),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  bru_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .pix_out    (pix_out)
  );

endmodule
